// File: rtl/core/bhpq_pkg.sv
// Shared types, sizes, status codes and key comparison for the binary heap priority queue.
package bhpq_pkg;

   localparam int HEAP_DEPTH = 1024;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int KEY_W      = 32;
   localparam int TAG_W      = 16;
   localparam int STATUS_W   = 2;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [TAG_W-1:0]        tag_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   // One heap slot
   typedef struct packed {
      key_type key;
      tag_type tag;
   } entry_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   // Strict ordering: a wins over b (larger for a max-heap, smaller for a min-heap)
   function automatic logic better(input key_type a, input key_type b, input logic order_max);
      logic res;
      res = order_max ? (a > b) : (a < b);
      return res;
   endfunction

endpackage

// File: rtl/core/binary_heap_priority_queue_top.sv
// Binary heap priority queue: sequencer around a two-read, one-write heap memory.
//
// Usage:
//   req_* channel (valid/ready) carries one operation: req_op insert or remove,
//   with req_key (signed) and req_tag for an insert. Each accepted request gives
//   exactly one transfer on the rsp_* channel: rsp_status, the removed root in
//   rsp_out_key/rsp_out_tag (zero otherwise) and rsp_count, the entries held after.
//   csr_* channel writes csr_order_max (1 = largest key at root, 0 = smallest);
//   it is always ready; the user writes it only while the queue is idle, which the block does not enforce.
// Timing:
//   One request is worked at a time. Each heap level is one step through the
//   heap memory (registered read data, parent or both children read together).
//   Full, empty or an insert into an empty queue go straight to the response
//   state; any other insert walks up from the new slot, and a remove reads root and
//   last entry and walks down only when the moved entry has a child. req_ready
//   is freed once the response is offered. A walk covers at most 9 levels at 1024 entries.
//   A result is held in an output register; when the receiver stalls with a
//   result still pending, the next request is worked and waits there to be sent.
// Reset:
//   Synchronous, active high: the queue is empty, order is max-heap. The memory
//   is not cleared, since only written slots are ever used.
module binary_heap_priority_queue_top (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic signed [bhpq_pkg::KEY_W-1:0] req_key,
   input  logic [bhpq_pkg::TAG_W-1:0]      req_tag,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bhpq_pkg::STATUS_W-1:0]   rsp_status,
   output logic signed [bhpq_pkg::KEY_W-1:0] rsp_out_key,
   output logic [bhpq_pkg::TAG_W-1:0]      rsp_out_tag,
   output logic [bhpq_pkg::CNT_W-1:0]      rsp_count,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_order_max
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_UP      = 6'b000010,
      S_DN_ROOT = 6'b000100,
      S_DN      = 6'b001000,
      S_FINAL   = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   localparam int IDX_W = bhpq_pkg::ADDR_W + 1;

   state_type               state_ff, state_in;
   logic                    order_ff;
   bhpq_pkg::cnt_type       count_ff, count_in;
   bhpq_pkg::addr_type      idx_ff, idx_in;
   bhpq_pkg::entry_type     ent_ff, ent_in;
   bhpq_pkg::status_type    res_status_ff, res_status_in;
   bhpq_pkg::entry_type     res_ent_ff, res_ent_in;

   logic                    rsp_valid_ff;
   bhpq_pkg::status_type    rsp_status_ff;
   bhpq_pkg::entry_type     rsp_ent_ff;
   bhpq_pkg::cnt_type       rsp_count_ff;
   logic                    rsp_load;

   // heap memory: one write port, two read ports, registered read data
   bhpq_pkg::entry_type     heap_mem [bhpq_pkg::HEAP_DEPTH];
   logic                    mem_we;
   bhpq_pkg::addr_type      mem_waddr;
   bhpq_pkg::entry_type     mem_wdata;
   bhpq_pkg::addr_type      rd_addr_a, rd_addr_b;
   bhpq_pkg::entry_type     rd_a_ff, rd_b_ff;

   // index arithmetic
   bhpq_pkg::addr_type      parent_idx, gparent_idx, child_idx;
   logic [IDX_W-1:0]        kid_l, kid_r, nkid_l, nkid_r, n_ext;
   logic                    take_r;
   bhpq_pkg::entry_type     child_ent;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

   // parent / child positions of the current hole
   always_comb begin
      parent_idx  = (idx_ff - bhpq_pkg::ADDR_W'(1)) >> 1;
      gparent_idx = (parent_idx - bhpq_pkg::ADDR_W'(1)) >> 1;
      kid_l       = {idx_ff, 1'b1};
      kid_r       = {idx_ff, 1'b0} + IDX_W'(2);
      n_ext       = IDX_W'(count_ff);
      take_r      = (kid_r < n_ext) &&
                    bhpq_pkg::better(rd_b_ff.key, rd_a_ff.key, order_ff);
      child_ent   = take_r ? rd_b_ff : rd_a_ff;
      child_idx   = take_r ? kid_r[bhpq_pkg::ADDR_W-1:0] : kid_l[bhpq_pkg::ADDR_W-1:0];
      nkid_l      = {child_idx, 1'b1};
      nkid_r      = {child_idx, 1'b0} + IDX_W'(2);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      ent_in        = ent_ff;
      res_status_in = res_status_ff;
      res_ent_in    = res_ent_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = ent_ff;
      rd_addr_a     = '0;
      rd_addr_b     = '0;
      rsp_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_ent_in    = '0;
               res_status_in = bhpq_pkg::STATUS_OK;
               if (req_op == bhpq_pkg::OP_INSERT) begin
                  if (count_ff == bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH)) begin
                     res_status_in = bhpq_pkg::STATUS_FULL;
                     state_in      = S_RESP;
                  end else begin
                     ent_in   = '{key: req_key, tag: req_tag};
                     idx_in   = count_ff[bhpq_pkg::ADDR_W-1:0];
                     count_in = count_ff + bhpq_pkg::CNT_W'(1);
                     if (count_ff == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = '{key: req_key, tag: req_tag};
                        state_in  = S_RESP;
                     end else begin
                        rd_addr_a = (count_ff[bhpq_pkg::ADDR_W-1:0]
                                     - bhpq_pkg::ADDR_W'(1)) >> 1;
                        state_in  = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = bhpq_pkg::STATUS_EMPTY;
                     state_in      = S_RESP;
                  end else begin
                     rd_addr_a = '0;
                     rd_addr_b = bhpq_pkg::ADDR_W'(count_ff - bhpq_pkg::CNT_W'(1));
                     count_in  = count_ff - bhpq_pkg::CNT_W'(1);
                     idx_in    = '0;
                     state_in  = S_DN_ROOT;
                  end
               end
            end
         end

         // rd_a holds the parent of the hole
         S_UP: begin
            mem_we = 1'b1;
            if (bhpq_pkg::better(ent_ff.key, rd_a_ff.key, order_ff)) begin
               mem_wdata = rd_a_ff;
               idx_in    = parent_idx;
               if (parent_idx == '0) begin
                  state_in = S_FINAL;
               end else begin
                  rd_addr_a = gparent_idx;
               end
            end else begin
               state_in = S_RESP;
            end
         end

         // rd_a holds the old root, rd_b the last entry that moves to the root
         S_DN_ROOT: begin
            res_ent_in = rd_a_ff;
            ent_in     = rd_b_ff;
            if (kid_l >= n_ext) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = rd_b_ff;
               state_in  = S_RESP;
            end else begin
               rd_addr_a = kid_l[bhpq_pkg::ADDR_W-1:0];
               rd_addr_b = kid_r[bhpq_pkg::ADDR_W-1:0];
               state_in  = S_DN;
            end
         end

         // rd_a / rd_b hold the left / right child of the hole
         S_DN: begin
            mem_we = 1'b1;
            if (bhpq_pkg::better(child_ent.key, ent_ff.key, order_ff)) begin
               mem_wdata = child_ent;
               idx_in    = child_idx;
               if (nkid_l >= n_ext) begin
                  state_in = S_FINAL;
               end else begin
                  rd_addr_a = nkid_l[bhpq_pkg::ADDR_W-1:0];
                  rd_addr_b = nkid_r[bhpq_pkg::ADDR_W-1:0];
               end
            end else begin
               state_in = S_RESP;
            end
         end

         S_FINAL: begin
            mem_we   = 1'b1;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid) begin
            order_ff <= csr_order_max;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      ent_ff        <= ent_in;
      res_status_ff <= res_status_in;
      res_ent_ff    <= res_ent_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_ent_ff    <= res_ent_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_out_key = rsp_ent_ff.key;
   assign rsp_out_tag = rsp_ent_ff.tag;
   assign rsp_count   = rsp_count_ff;

`ifndef SYNTH
   // entry count never passes the heap depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bhpq_pkg::CNT_W'(bhpq_pkg::HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   // sift-down only runs while the hole has a left child in range
   a_dn_child: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN) |-> (kid_l < n_ext))
      else $error("sift-down past the last entry");

   // a new response only comes out of the response state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");

   // the heap memory is not written while idle with no request pending
   a_idle_nowrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |-> !mem_we)
      else $error("heap write while idle");
`endif

endmodule
